// File: hdl/mkrs_pkg.sv
// ----------------------------------------------------------------------------
// mkrs_pkg
// Shared types, constants and the record ordering function of the
// multi-key record sorter.
// ----------------------------------------------------------------------------
package mkrs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int CODE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int AGE_W   = 8;
  localparam int TAG_W   = 6;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [SCORE_W-1:0] score;
    logic [AGE_W-1:0]   age;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic ins;    // insert the incoming record
    logic shift;  // pop the head record toward the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic one_left;  // head record is the final one of the set
  } status_t;

  // a leaves before b: score descending, age ascending, code ascending
  function automatic logic rec_before(input rec_t a, input rec_t b);
    logic res;
    if (a.score != b.score) begin
      res = (a.score > b.score);
    end else if (a.age != b.age) begin
      res = (a.age < b.age);
    end else begin
      res = (a.code < b.code);
    end
    return res;
  endfunction

endpackage

// File: hdl/mkrs_ctrl.sv
// ----------------------------------------------------------------------------
// mkrs_ctrl
// Load / emit sequencer of the record sorter. Drives the handshakes and
// issues insert and shift commands to the record chain.
// ----------------------------------------------------------------------------
module mkrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_in,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mkrs_pkg::status_t status,
  output mkrs_pkg::cmd_t    cmd
);

  mkrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mkrs_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mkrs_pkg::ST_LOAD: begin
        if (in_valid && in_last_in) begin
          state_nxt = mkrs_pkg::ST_EMIT;
        end
      end
      mkrs_pkg::ST_EMIT: begin
        if (!out_stall && status.one_left) begin
          state_nxt = mkrs_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mkrs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      mkrs_pkg::ST_LOAD: begin
        cmd.ins = in_valid;
      end
      mkrs_pkg::ST_EMIT: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
        cmd.shift = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/mkrs_chain.sv
// ----------------------------------------------------------------------------
// mkrs_chain
// Sorted insertion chain. Every cell compares the incoming record with its
// own in parallel; the chain opens a gap at the insertion point and writes
// the record into it. During emission the chain shifts toward cell 0,
// which feeds the output.
// ----------------------------------------------------------------------------
module mkrs_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  mkrs_pkg::cmd_t    cmd,
  input  mkrs_pkg::rec_t    rec_in,
  output mkrs_pkg::rec_t    rec_head,
  output logic              dropped,
  output mkrs_pkg::status_t status
);

  localparam int N = mkrs_pkg::MAX_RECORDS;

  mkrs_pkg::rec_t store_r   [N];
  mkrs_pkg::rec_t store_nxt [N];

  logic [mkrs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       dropped_r, dropped_nxt;
  logic [N-1:0]               goes_before;
  logic                       full;

  assign full = (count_r == mkrs_pkg::CNT_W'(N));

  // chain stays sorted, so goes_before is 0...0 1...1 over valid cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    assign goes_before[k] = (mkrs_pkg::CNT_W'(k) < count_r) &&
                            mkrs_pkg::rec_before(rec_in, store_r[k]);

    always_comb begin
      store_nxt[k] = store_r[k];
      if (cmd.shift) begin
        if (k < N - 1) begin
          store_nxt[k] = store_r[(k < N - 1) ? k + 1 : k];
        end
      end else if (cmd.ins && !full) begin
        if (goes_before[k]) begin
          if (k == 0) begin
            store_nxt[k] = rec_in;
          end else if (!goes_before[(k > 0) ? k - 1 : 0]) begin
            store_nxt[k] = rec_in;
          end else begin
            store_nxt[k] = store_r[(k > 0) ? k - 1 : 0];
          end
        end else if (mkrs_pkg::CNT_W'(k) == count_r) begin
          // first free cell takes the record pushed down by an insertion, or the new record when it sorts last
          if (k > 0 && goes_before[(k > 0) ? k - 1 : 0]) begin
            store_nxt[k] = store_r[(k > 0) ? k - 1 : 0];
          end else begin
            store_nxt[k] = rec_in;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      store_r[k] <= store_nxt[k];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.shift) begin
      count_nxt = count_r - 1'b1;
      if (status.one_left) begin
        dropped_nxt = 1'b0;  // set done, start the next one clean
      end
    end else if (cmd.ins) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign rec_head        = store_r[0];
  assign dropped         = dropped_r;
  assign status.one_left = (count_r == mkrs_pkg::CNT_W'(1));

endmodule

// File: hdl/multi_key_record_sorter.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter
// Collects a set of records and emits them sorted by score descending,
// age ascending, code ascending (stable on full ties).
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_code in_score in_age in_tag in_last_in
//   out      out_valid/ out_stall out_code out_score out_age out_tag
//                                 out_last_out out_overflow
//
// Loading takes one record per cycle: all chain cells compare in parallel.
// After the last_in transaction the input stalls while the set drains, one
// result per cycle from the head cell while out_stall is low.
// Output stall freezes the head record and the chain.
// Reset empties the chain and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module multi_key_record_sorter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mkrs_pkg::CODE_W-1:0]   in_code,
  input  logic [mkrs_pkg::SCORE_W-1:0]  in_score,
  input  logic [mkrs_pkg::AGE_W-1:0]    in_age,
  input  logic [mkrs_pkg::TAG_W-1:0]    in_tag,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mkrs_pkg::CODE_W-1:0]   out_code,
  output logic [mkrs_pkg::SCORE_W-1:0]  out_score,
  output logic [mkrs_pkg::AGE_W-1:0]    out_age,
  output logic [mkrs_pkg::TAG_W-1:0]    out_tag,
  output logic                          out_last_out,
  output logic                          out_overflow
);

  mkrs_pkg::cmd_t    cmd;
  mkrs_pkg::status_t status;
  mkrs_pkg::rec_t    rec_in;
  mkrs_pkg::rec_t    rec_head;
  logic              dropped;

  assign rec_in.code  = in_code;
  assign rec_in.score = in_score;
  assign rec_in.age   = in_age;
  assign rec_in.tag   = in_tag;

  mkrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_last_in (in_last_in),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mkrs_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rec_in   (rec_in),
    .rec_head (rec_head),
    .dropped  (dropped),
    .status   (status)
  );

  assign out_code     = rec_head.code;
  assign out_score    = rec_head.score;
  assign out_age      = rec_head.age;
  assign out_tag      = rec_head.tag;
  assign out_last_out = status.one_left;
  assign out_overflow = dropped;

endmodule
